// ----- rtl/id3_pkg.sv -----
package id3_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int SIZE_W     = 32;
    localparam int HDR_CNT_W  = 2;
    localparam int SIZE_CNT_W = 2;
    localparam int TEXT_WORDS = 4;
    localparam int TEXT_BYTES = TEXT_WORDS * WORD_W / BYTE_W;
    localparam int TEXT_SEL_W = $clog2(TEXT_BYTES);

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BEGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_WORD0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_WORD1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_WORD2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_WORD3  = 3'd5;

    // Reset values of the match characters ('T' and '2')
    localparam logic [BYTE_W-1:0] FRAME_BEGIN_RST = 8'h54;
    localparam logic [BYTE_W-1:0] FRAME_END_RST   = 8'h32;

    // Last index of the size field and of the header bytes
    localparam logic [SIZE_CNT_W-1:0] SIZE_LAST = 2'd3;
    localparam logic [HDR_CNT_W-1:0]  HDR_LAST  = 2'd2;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_SIZE    = 3'd1,
        PH_HEADER  = 3'd2,
        PH_REPLACE = 3'd3,
        PH_PASS    = 3'd4
    } phase_t;

endpackage

// ----- rtl/id3_in_if.sv -----
interface id3_in_if;
    logic                      valid;
    logic                      ready;
    logic [id3_pkg::BYTE_W-1:0] in_byte;
    logic                      end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

// ----- rtl/id3_out_if.sv -----
interface id3_out_if;
    logic                      valid;
    logic                      ready;
    logic [id3_pkg::BYTE_W-1:0] out_byte;
    logic                      out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- rtl/id3_text_frame_rewriter.sv -----
// Byte stream rewriter for one ID3v2.3 text frame. Each input byte yields one
// output byte, one transaction per clock: the phase update and the byte select
// sit between the input handshake and a single output register, so a new byte
// is taken every cycle while the output side takes its results (input ready is
// held only while the output register is full and stalled). A result is held in
// the output register from the cycle after its byte is taken.
// Bytes pass through
// until frame_begin then frame_end are seen; the four size bytes and three
// header bytes pass through, then size-1 bytes are replaced by the configured
// text (zero padded), then the rest passes. A byte with end_of_file set is
// marked out_last and returns the matcher to its search phase. Configuration
// writes (match characters, four 64-bit text words) must be made while idle.
module id3_text_frame_rewriter #(
    parameter int MAX_TEXT = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [id3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [id3_pkg::WORD_W-1:0]    cfg_data,
    id3_in_if.sink                        in_ch,
    id3_out_if.source                     out_ch
);

    localparam int IDX_W = $clog2(MAX_TEXT + 1);

    // Configuration registers
    logic [id3_pkg::BYTE_W-1:0] frame_begin_reg;
    logic [id3_pkg::BYTE_W-1:0] frame_end_reg;
    logic [id3_pkg::TEXT_BYTES*id3_pkg::BYTE_W-1:0] text_reg;

    // Matcher state
    id3_pkg::phase_t                phase_reg, phase_next;
    logic                           armed_reg, armed_next;
    logic [id3_pkg::SIZE_CNT_W-1:0] size_count_reg, size_count_next;
    logic [id3_pkg::SIZE_W-1:0]     frame_size_reg, frame_size_next;
    logic [id3_pkg::HDR_CNT_W-1:0]  header_count_reg, header_count_next;
    logic [IDX_W-1:0]               text_index_reg, text_index_next;
    logic                           text_ended_reg, text_ended_next;

    // Output register
    logic                       out_valid_reg;
    logic [id3_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       out_last_reg;

    logic                           accept;
    logic                           now_armed;
    logic [id3_pkg::SIZE_W-1:0]     size_shift;
    logic [id3_pkg::SIZE_W-1:0]     size_dec;
    logic [id3_pkg::TEXT_SEL_W-1:0] text_sel;
    logic [id3_pkg::BYTE_W-1:0]     text_char;
    logic [id3_pkg::BYTE_W-1:0]     repl_char;

    assign in_ch.ready     = !out_valid_reg || out_ch.ready;
    assign accept          = in_ch.valid && in_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

    // Configuration writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_begin_reg <= id3_pkg::FRAME_BEGIN_RST;
            frame_end_reg   <= id3_pkg::FRAME_END_RST;
            text_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                id3_pkg::REG_FRAME_BEGIN: frame_begin_reg <= cfg_data[id3_pkg::BYTE_W-1:0];
                id3_pkg::REG_FRAME_END:   frame_end_reg   <= cfg_data[id3_pkg::BYTE_W-1:0];
                id3_pkg::REG_TEXT_WORD0:  text_reg[0*id3_pkg::WORD_W +: id3_pkg::WORD_W] <= cfg_data;
                id3_pkg::REG_TEXT_WORD1:  text_reg[1*id3_pkg::WORD_W +: id3_pkg::WORD_W] <= cfg_data;
                id3_pkg::REG_TEXT_WORD2:  text_reg[2*id3_pkg::WORD_W +: id3_pkg::WORD_W] <= cfg_data;
                id3_pkg::REG_TEXT_WORD3:  text_reg[3*id3_pkg::WORD_W +: id3_pkg::WORD_W] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared datapath terms
    assign now_armed  = armed_reg || (in_ch.in_byte == frame_begin_reg);
    assign size_shift = {frame_size_reg[id3_pkg::SIZE_W-id3_pkg::BYTE_W-1:0], in_ch.in_byte};
    assign size_dec   = frame_size_reg - id3_pkg::SIZE_W'(1);
    assign text_sel   = id3_pkg::TEXT_SEL_W'(text_index_reg);
    assign text_char  = text_reg[text_sel*id3_pkg::BYTE_W +: id3_pkg::BYTE_W];
    assign repl_char  = (!text_ended_reg && (text_index_reg < IDX_W'(MAX_TEXT)))
                        ? text_char : '0;

    // Next state
    always_comb
    begin
        phase_next        = phase_reg;
        armed_next        = armed_reg;
        size_count_next   = size_count_reg;
        frame_size_next   = frame_size_reg;
        header_count_next = header_count_reg;
        text_index_next   = text_index_reg;
        text_ended_next   = text_ended_reg;

        unique case (phase_reg)
            id3_pkg::PH_SEARCH:
            begin
                if (now_armed && (in_ch.in_byte == frame_end_reg))
                begin
                    armed_next      = 1'b0;
                    phase_next      = id3_pkg::PH_SIZE;
                    size_count_next = '0;
                    frame_size_next = '0;
                end
                else
                begin
                    armed_next = now_armed;
                end
            end
            id3_pkg::PH_SIZE:
            begin
                if (size_count_reg >= id3_pkg::SIZE_LAST)
                begin
                    size_count_next   = '0;
                    frame_size_next   = (size_shift >= id3_pkg::SIZE_W'(2))
                                        ? size_shift - id3_pkg::SIZE_W'(1) : '0;
                    header_count_next = '0;
                    phase_next        = id3_pkg::PH_HEADER;
                end
                else
                begin
                    size_count_next = size_count_reg + id3_pkg::SIZE_CNT_W'(1);
                    frame_size_next = size_shift;
                end
            end
            id3_pkg::PH_HEADER:
            begin
                if (header_count_reg >= id3_pkg::HDR_LAST)
                begin
                    header_count_next = '0;
                    text_index_next   = '0;
                    text_ended_next   = 1'b0;
                    phase_next        = (frame_size_reg != '0)
                                        ? id3_pkg::PH_REPLACE : id3_pkg::PH_PASS;
                end
                else
                begin
                    header_count_next = header_count_reg + id3_pkg::HDR_CNT_W'(1);
                end
            end
            id3_pkg::PH_REPLACE:
            begin
                if (repl_char == '0)
                    text_ended_next = 1'b1;
                else
                    text_index_next = text_index_reg + IDX_W'(1);
                frame_size_next = size_dec;
                if (size_dec == '0)
                    phase_next = id3_pkg::PH_PASS;
            end
            default: ;
        endcase

        // End of file: back to the search phase
        if (in_ch.end_of_file)
        begin
            phase_next        = id3_pkg::PH_SEARCH;
            armed_next        = 1'b0;
            size_count_next   = '0;
            frame_size_next   = '0;
            header_count_next = '0;
            text_index_next   = '0;
            text_ended_next   = 1'b0;
        end
    end

    // Output byte select
    always_comb
    begin
        unique case (phase_reg)
            id3_pkg::PH_REPLACE: out_byte_next = repl_char;
            default:             out_byte_next = in_ch.in_byte;
        endcase
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= id3_pkg::PH_SEARCH;
            armed_reg        <= 1'b0;
            size_count_reg   <= '0;
            frame_size_reg   <= '0;
            header_count_reg <= '0;
            text_index_reg   <= '0;
            text_ended_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                armed_reg        <= armed_next;
                size_count_reg   <= size_count_next;
                frame_size_reg   <= frame_size_next;
                header_count_reg <= header_count_next;
                text_index_reg   <= text_index_next;
                text_ended_reg   <= text_ended_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= in_ch.end_of_file;
        end
    end

endmodule

// ----- verif/id3_text_frame_rewriter_test.sv -----
module id3_text_frame_rewriter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_MAX        = 32;
    localparam int N_SETTINGS      = 6;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int N_DIRECTED      = 27;

    typedef struct packed {
        logic [id3_pkg::BYTE_W-1:0] b;
        logic                       last;
    } out_item_t;

    // One directed transaction: input byte, end-of-file flag, expected byte.
    // The expected last flag always equals the end-of-file flag.
    typedef struct packed {
        logic [id3_pkg::BYTE_W-1:0] b;
        logic                       eof;
        logic [id3_pkg::BYTE_W-1:0] want;
    } dir_row_t;

    // Reset match characters are 'T' (0x54) and '2' (0x32), text is empty
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b0, 8'h00},   // lowest byte passes
        '{8'hFF, 1'b1, 8'hFF},   // highest byte, end of file while searching
        '{8'h32, 1'b0, 8'h32},   // end character without arming: no match
        '{8'h54, 1'b0, 8'h54},   // arms
        '{8'h41, 1'b0, 8'h41},
        '{8'h32, 1'b0, 8'h32},   // completes the match
        '{8'h00, 1'b0, 8'h00},   // size, big-endian: 3
        '{8'h00, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00},
        '{8'h03, 1'b0, 8'h03},
        '{8'h54, 1'b0, 8'h54},   // header: match characters are ignored
        '{8'h32, 1'b0, 8'h32},
        '{8'h01, 1'b0, 8'h01},
        '{8'hA5, 1'b0, 8'h00},   // two bytes replaced, text empty so zero
        '{8'h5A, 1'b0, 8'h00},
        '{8'h54, 1'b0, 8'h54},   // pass-through after the frame
        '{8'h32, 1'b1, 8'h32},   // end of file returns to search
        '{8'h54, 1'b0, 8'h54},
        '{8'h32, 1'b0, 8'h32},
        '{8'h00, 1'b0, 8'h00},   // size 1: nothing is replaced
        '{8'h00, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00},
        '{8'h01, 1'b0, 8'h01},
        '{8'h80, 1'b0, 8'h80},
        '{8'h7F, 1'b0, 8'h7F},
        '{8'h01, 1'b0, 8'h01},
        '{8'h33, 1'b1, 8'h33}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [id3_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [id3_pkg::WORD_W-1:0]    cfg_data;

    id3_in_if  in_ch ();
    id3_out_if out_ch ();

    id3_text_frame_rewriter #(
        .MAX_TEXT (TEXT_MAX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Local copy of the registers
    logic [id3_pkg::BYTE_W-1:0] cfg_begin;
    logic [id3_pkg::BYTE_W-1:0] cfg_end;
    logic [id3_pkg::WORD_W-1:0] cfg_text [id3_pkg::TEXT_WORDS];

    // Local copy of the matcher state
    id3_pkg::phase_t                rw_phase;
    logic                           rw_armed;
    logic [id3_pkg::SIZE_CNT_W-1:0] rw_size_cnt;
    logic [id3_pkg::SIZE_W-1:0]     rw_size;
    logic [id3_pkg::HDR_CNT_W-1:0]  rw_hdr_cnt;
    logic [5:0]                     rw_text_idx;
    logic                           rw_text_done;

    out_item_t rewritten_q [$];
    out_item_t want_item;

    logic gaps_on;
    int   items_sent;
    int   files_sent;
    int   results_seen;
    int   mismatch_count;
    int   phase_start;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                 rewritten_q.size());
        $display("id3_text_frame_rewriter_test NOT OK");
        $finish;
    end

    function automatic void clear_rewriter();
        rw_phase     = id3_pkg::PH_SEARCH;
        rw_armed     = 1'b0;
        rw_size_cnt  = '0;
        rw_size      = '0;
        rw_hdr_cnt   = '0;
        rw_text_idx  = '0;
        rw_text_done = 1'b0;
    endfunction

    // Advance the matcher by one byte and return the rewritten byte
    function automatic out_item_t rewrite_byte(input logic [id3_pkg::BYTE_W-1:0] b,
                                               input logic last);
        out_item_t                  res;
        logic                       hit;
        logic [id3_pkg::SIZE_W-1:0] grown;
        logic [4:0]                 k;
        res.b = b;
        res.last = last;
        case (rw_phase)
            id3_pkg::PH_SEARCH:
            begin
                hit = rw_armed || (b == cfg_begin);
                if (hit && b == cfg_end)
                begin
                    rw_armed    = 1'b0;
                    rw_phase    = id3_pkg::PH_SIZE;
                    rw_size_cnt = '0;
                    rw_size     = '0;
                end
                else
                    rw_armed = hit;
            end
            id3_pkg::PH_SIZE:
            begin
                grown = {rw_size[id3_pkg::SIZE_W-id3_pkg::BYTE_W-1:0], b};
                if (rw_size_cnt == id3_pkg::SIZE_LAST)
                begin
                    rw_size_cnt = '0;
                    rw_size     = (grown >= id3_pkg::SIZE_W'(2))
                                  ? grown - id3_pkg::SIZE_W'(1) : '0;
                    rw_hdr_cnt  = '0;
                    rw_phase    = id3_pkg::PH_HEADER;
                end
                else
                begin
                    rw_size     = grown;
                    rw_size_cnt = rw_size_cnt + id3_pkg::SIZE_CNT_W'(1);
                end
            end
            id3_pkg::PH_HEADER:
            begin
                if (rw_hdr_cnt == id3_pkg::HDR_LAST)
                begin
                    rw_hdr_cnt   = '0;
                    rw_text_idx  = '0;
                    rw_text_done = 1'b0;
                    if (rw_size != '0)
                        rw_phase = id3_pkg::PH_REPLACE;
                    else
                        rw_phase = id3_pkg::PH_PASS;
                end
                else
                    rw_hdr_cnt = rw_hdr_cnt + id3_pkg::HDR_CNT_W'(1);
            end
            id3_pkg::PH_REPLACE:
            begin
                res.b = 8'h00;
                if (!rw_text_done && rw_text_idx < 6'(TEXT_MAX))
                begin
                    k = rw_text_idx[4:0];
                    res.b = cfg_text[k[4:3]][k[2:0]*8 +: 8];
                end
                // a zero byte ends the text, padding follows
                if (res.b == 8'h00)
                    rw_text_done = 1'b1;
                else
                    rw_text_idx = rw_text_idx + 6'(1);
                rw_size = rw_size - id3_pkg::SIZE_W'(1);
                if (rw_size == '0)
                    rw_phase = id3_pkg::PH_PASS;
            end
            default:
            begin
            end
        endcase
        if (last)
            clear_rewriter();
        return res;
    endfunction

    // Register write, block idle
    task automatic write_reg(input logic [id3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [id3_pkg::WORD_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            id3_pkg::REG_FRAME_BEGIN: cfg_begin   = data[id3_pkg::BYTE_W-1:0];
            id3_pkg::REG_FRAME_END:   cfg_end     = data[id3_pkg::BYTE_W-1:0];
            id3_pkg::REG_TEXT_WORD0:  cfg_text[0] = data;
            id3_pkg::REG_TEXT_WORD1:  cfg_text[1] = data;
            id3_pkg::REG_TEXT_WORD2:  cfg_text[2] = data;
            id3_pkg::REG_TEXT_WORD3:  cfg_text[3] = data;
            default:
            begin
            end
        endcase
    endtask

    // One input transaction; typed rows replace the predicted byte
    task automatic send_byte(input logic [id3_pkg::BYTE_W-1:0] b, input logic eof,
                             input logic typed, input logic [id3_pkg::BYTE_W-1:0] typed_b);
        out_item_t pred;
        while (gaps_on && $urandom_range(99) < 24)
        begin
            in_ch.valid       = 1'b0;
            in_ch.in_byte     = 8'($urandom);
            in_ch.end_of_file = 1'($urandom);
            @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.in_byte     = b;
        in_ch.end_of_file = eof;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pred = rewrite_byte(b, eof);
        if (typed)
        begin
            pred.b    = typed_b;
            pred.last = eof;
        end
        rewritten_q.push_back(pred);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every result has come out, then a short pause
    task automatic settle();
        in_ch.valid = 1'b0;
        while (rewritten_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly well-formed files: lead bytes, match, size, header, body;
    // some are plain noise, some are cut short by the end-of-file mark
    task automatic send_file();
        logic [id3_pkg::BYTE_W-1:0] body [$];
        logic [id3_pkg::SIZE_W-1:0] fsize;
        int                         n;
        int                         cut;
        int                         pick;
        body = {};
        repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
        if ($urandom_range(99) < 85)
        begin
            body.push_back(cfg_begin);
            repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
            body.push_back(cfg_end);
            pick = int'($urandom_range(99));
            if (pick < 10)
                fsize = $urandom_range(0, 1);
            else if (pick < 20)
                fsize = $urandom;
            else
                fsize = $urandom_range(2, 40);
            for (int s = 3; s >= 0; s--)
                body.push_back(fsize[s*8 +: 8]);
            repeat (3) body.push_back(8'($urandom));
            if (fsize <= 40)
                n = int'(fsize) + int'($urandom_range(0, 6));
            else
                n = int'($urandom_range(0, 20));
            repeat (n) body.push_back(8'($urandom));
        end
        else
            repeat ($urandom_range(1, 20)) body.push_back(8'($urandom));
        cut = body.size();
        if ($urandom_range(99) < 15)
            cut = int'($urandom_range(1, body.size()));
        for (int i = 0; i < cut; i++)
            send_byte(body[i], i == cut - 1, 1'b0, 8'h00);
        files_sent++;
    endtask

    // Register settings: extremes first, then begin equal to end, then random
    task automatic load_settings(input int p);
        logic [id3_pkg::BYTE_W-1:0] b_ch;
        logic [id3_pkg::BYTE_W-1:0] e_ch;
        logic [id3_pkg::WORD_W-1:0] words [id3_pkg::TEXT_WORDS];
        int                         len;
        b_ch = 8'($urandom);
        e_ch = 8'($urandom);
        len  = int'($urandom_range(0, id3_pkg::TEXT_BYTES));
        case (p)
            0:
            begin
                b_ch = 8'h00;
                e_ch = 8'hFF;
                len  = id3_pkg::TEXT_BYTES;
            end
            1:
            begin
                b_ch = 8'hFF;
                e_ch = 8'h00;
                len  = 0;
            end
            2: e_ch = b_ch;
            default:
            begin
            end
        endcase
        for (int k = 0; k < id3_pkg::TEXT_BYTES; k++)
        begin
            if (k >= len)
                words[k/8][(k%8)*8 +: 8] = 8'h00;
            else if (p == 0)
                words[k/8][(k%8)*8 +: 8] = 8'hFF;
            else
                words[k/8][(k%8)*8 +: 8] = 8'($urandom_range(1, 255));
        end
        // fully random words, zero bytes may fall anywhere
        if (p == 3)
            foreach (words[w])
                words[w] = {$urandom, $urandom};
        write_reg(id3_pkg::REG_FRAME_BEGIN,
                  {{(id3_pkg::WORD_W-id3_pkg::BYTE_W){1'b0}}, b_ch});
        write_reg(id3_pkg::REG_FRAME_END,
                  {{(id3_pkg::WORD_W-id3_pkg::BYTE_W){1'b0}}, e_ch});
        write_reg(id3_pkg::REG_TEXT_WORD0, words[0]);
        write_reg(id3_pkg::REG_TEXT_WORD1, words[1]);
        write_reg(id3_pkg::REG_TEXT_WORD2, words[2]);
        write_reg(id3_pkg::REG_TEXT_WORD3, words[3]);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Output side: random stalls
    always @(negedge clk)
        out_ch.ready = !gaps_on || ($urandom_range(99) >= 24);

    // Compare each output transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (rewritten_q.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          out_ch.out_byte, out_ch.out_last));
            else
            begin
                want_item = rewritten_q.pop_front();
                if (out_ch.out_byte !== want_item.b)
                    report_mismatch($sformatf("out_byte expected %02h got %02h",
                                              want_item.b, out_ch.out_byte));
                if (out_ch.out_last !== want_item.last)
                    report_mismatch($sformatf("out_last expected %0b got %0b",
                                              want_item.last, out_ch.out_last));
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = '0;
        in_ch.end_of_file = 1'b0;
        out_ch.ready      = 1'b0;
        gaps_on           = 1'b1;
        items_sent        = 0;
        files_sent        = 0;
        results_seen      = 0;
        mismatch_count    = 0;
        cfg_begin         = id3_pkg::FRAME_BEGIN_RST;
        cfg_end           = id3_pkg::FRAME_END_RST;
        foreach (cfg_text[w])
            cfg_text[w] = '0;
        clear_rewriter();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under reset register values
        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[i].b, DIRECTED[i].eof, 1'b1, DIRECTED[i].want);

        // Random part, one register setting per phase; phase 1 runs without stalls
        for (int p = 0; p < N_SETTINGS; p++)
        begin
            settle();
            gaps_on = (p != 1);
            load_settings(p);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
                send_file();
        end
        settle();

        $display("%0d bytes in %0d random files plus %0d directed, %0d register settings",
                 items_sent, files_sent, N_DIRECTED, N_SETTINGS);
        $display("%0d output transactions checked, %0d mismatches", results_seen,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("id3_text_frame_rewriter_test OK");
        else
            $display("id3_text_frame_rewriter_test NOT OK");
        $finish;
    end

endmodule

// ----- id3_text_frame_rewriter.f -----
rtl/id3_pkg.sv
rtl/id3_in_if.sv
rtl/id3_out_if.sv
rtl/id3_text_frame_rewriter.sv
verif/id3_text_frame_rewriter_test.sv
